// ===== hw/rtl/pdsl_pkg.sv =====
`default_nettype none

package pdsl_pkg;

   localparam int POS_W   = 16;
   localparam int ERR_W   = 17;
   localparam int TIME_W  = 32;
   localparam int GAIN_W  = 16;
   localparam int SLEW_W  = 15;
   localparam int HOLD_W  = 16;
   localparam int THR_W   = 16;
   localparam int DER_W   = 26;
   localparam int DIFF_W  = 18;
   localparam int QUO_W   = 25;
   localparam int CNT_W   = 5;
   localparam int PROD_W  = 42;
   localparam int SUM_W   = 43;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(QUO_W - 1);

   localparam logic [SLEW_W-1:0] SLEW_RESET = 15'h7FFF;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_P_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_D_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_MUL_P,
      ST_MUL_D,
      ST_SUM,
      ST_SCALE,
      ST_SLEW_DONE
   } pdsl_state_type;

   typedef struct packed {
      logic               start;
      logic [QUO_W-1:0]   dividend;
      logic [TIME_W-1:0]  divisor;
   } pdsl_div_req_type;

   typedef struct packed {
      logic               done;
      logic [QUO_W-1:0]   quotient;
   } pdsl_div_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pdsl_divider.sv =====
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module pdsl_divider
   import pdsl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pdsl_div_req_type div_req,
   output pdsl_div_rsp_type      div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [TIME_W-1:0] divisor_ff, divisor_in;
   logic [TIME_W+1:0] trial;
   logic              fits;

   always_comb begin
      trial = {1'b0, rem_ff, quo_ff[QUO_W-1]} - {2'b00, divisor_ff};
      fits  = ~trial[TIME_W+1];

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_LAST_STEP;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[TIME_W-1:0] : {rem_ff[TIME_W-2:0], quo_ff[QUO_W-1]};
         quo_in = {quo_ff[QUO_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pdsl_mul.sv =====
`default_nettype none

// Shared signed multiplier with a registered product.
module pdsl_mul
   import pdsl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [GAIN_W-1:0] mul_a,
   input  wire logic signed [DER_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]      product
);

   logic signed [PROD_W-1:0] product_ff, product_in;

   assign product_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pd_controller_with_slew_limit.sv =====
// PD position controller with a slew-rate limited drive.
// Input channel (req_): one beat per control tick carries a signed position
// sample and a free-running millisecond timestamp. Result channel (rsp_):
// one beat per tick carries the limited drive, the error and a settled flag.
// Configuration (csr_): a write at csr_index with csr_wdata is taken on any
// clock edge with csr_we high; write only while no tick is in progress.
// An accepted tick passes CHECK, MUL_P, MUL_D, SUM, SCALE and SLEW_DONE before
// rsp_valid when the held derivative is kept, with DIV after CHECK when it is
// refreshed: the refresh runs a 25-step restoring divider, one quotient bit per
// cycle. The two products then share one multiplier. One tick is in work at a
// time, so a new tick is accepted only once the last one has left SLEW_DONE.
// Reset clears the state and loads the register defaults: zero target and
// gains, slew limit 32767, hold time 100 ms, settle threshold zero.
// If the receiver stalls, the finished beat stays in the output register
// and the next tick may still be accepted and computed; the block then waits
// with that result until the output register is free.
`default_nettype none

module pd_controller_with_slew_limit
   import pdsl_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [POS_W-1:0]      req_position,
   input  wire logic [TIME_W-1:0]            req_time_ms,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [POS_W-1:0]           rsp_drive,
   output logic signed [ERR_W-1:0]           rsp_error_now,
   output logic                              rsp_settled,
   input  wire logic                         csr_we,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);

   // Sequencer.
   pdsl_state_type state_ff, state_in;

   // Configuration registers.
   logic signed [POS_W-1:0]  target_ff, target_in;
   logic signed [GAIN_W-1:0] p_gain_ff, p_gain_in;
   logic signed [GAIN_W-1:0] d_gain_ff, d_gain_in;
   logic [SLEW_W-1:0]        slew_ff, slew_in;
   logic [HOLD_W-1:0]        hold_ff, hold_in;
   logic [THR_W-1:0]         thr_ff, thr_in;

   // Controller state carried across ticks.
   logic [TIME_W-1:0]        last_time_ff, last_time_in;
   logic signed [ERR_W-1:0]  last_error_ff, last_error_in;
   logic signed [DER_W-1:0]  deriv_ff, deriv_in;
   logic signed [POS_W-1:0]  last_drive_ff, last_drive_in;

   // Per-tick working registers.
   logic signed [ERR_W-1:0]  error_ff, error_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic                     neg_ff, neg_in;
   logic signed [PROD_W-1:0] pprod_ff, pprod_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [POS_W-1:0]  cmd_ff, cmd_in;
   logic signed [POS_W-1:0]  drive_ff, drive_in;
   logic                     settled_ff, settled_in;
   logic                     pending_ff, pending_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]  rsp_drive_ff, rsp_drive_in;
   logic signed [ERR_W-1:0]  rsp_error_ff, rsp_error_in;
   logic                     rsp_settled_ff, rsp_settled_in;

   // Sequencer outputs.
   logic                     accept;
   logic                     div_start;
   logic                     sel_d_term;

   pdsl_div_req_type         div_req;
   pdsl_div_rsp_type         div_rsp;
   logic signed [GAIN_W-1:0] mul_a;
   logic signed [DER_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] product;

   // Datapath intermediates.
   logic [TIME_W-1:0]        dt;
   logic                     refresh;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_mag;
   logic signed [SUM_W-16-1:0] scaled;
   logic signed [DIFF_W-1:0] delta;
   logic signed [DIFF_W-1:0] limit;
   logic signed [DIFF_W-1:0] last_ext;
   logic [ERR_W-1:0]         err_mag;
   logic                     out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   // The refresh test: a changed error, or more than the hold time elapsed.
   // The elapsed time wraps, so a timestamp moving backwards looks long.
   assign dt       = now_ff - last_time_ff;
   assign refresh  = (error_ff != last_error_ff) || (dt > {16'd0, hold_ff});
   assign diff     = DIFF_W'(error_ff) - DIFF_W'(last_error_ff);
   assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = refresh ? ST_DIV : ST_MUL_P;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P:  state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_SUM;
         ST_SUM:    state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_SLEW_DONE;
         ST_SLEW_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer outputs.
   // ------------------------------------------------------------------
   always_comb begin
      req_ready  = 1'b0;
      div_start  = 1'b0;
      sel_d_term = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_ready  = 1'b1;
         ST_CHECK:     div_start  = refresh;
         ST_MUL_D:     sel_d_term = 1'b1;
         default: begin
         end
      endcase
   end

   assign accept = req_valid & req_ready;

   // The divider works on magnitudes; a zero interval divides as one.
   assign div_req.start    = div_start;
   assign div_req.dividend = {diff_mag[ERR_W-1:0], 8'd0};
   assign div_req.divisor  = (dt == '0) ? TIME_W'(1) : dt;

   pdsl_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // One multiplier serves both terms: P times error, then D times derivative.
   assign mul_a = sel_d_term ? d_gain_ff : p_gain_ff;
   assign mul_b = sel_d_term ? deriv_ff : DER_W'(error_ff);

   pdsl_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // ------------------------------------------------------------------
   // Datapath.
   // ------------------------------------------------------------------
   always_comb begin
      target_in     = target_ff;
      p_gain_in     = p_gain_ff;
      d_gain_in     = d_gain_ff;
      slew_in       = slew_ff;
      hold_in       = hold_ff;
      thr_in        = thr_ff;
      last_time_in  = last_time_ff;
      last_error_in = last_error_ff;
      deriv_in      = deriv_ff;
      last_drive_in = last_drive_ff;
      error_in      = error_ff;
      now_in        = now_ff;
      neg_in        = neg_ff;
      pprod_in      = pprod_ff;
      sum_in        = sum_ff;
      cmd_in        = cmd_ff;
      drive_in      = drive_ff;
      settled_in    = settled_ff;
      pending_in    = pending_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_drive_in  = rsp_drive_ff;
      rsp_error_in  = rsp_error_ff;
      rsp_settled_in = rsp_settled_ff;

      scaled   = sum_ff[SUM_W-1:16] + (SUM_W-16)'(sum_ff[SUM_W-1] & (|sum_ff[15:0]));
      last_ext = DIFF_W'(last_drive_ff);
      delta    = DIFF_W'(cmd_ff) - last_ext;
      limit    = DIFF_W'({1'b0, slew_ff});
      err_mag  = error_ff[ERR_W-1] ? ERR_W'(-error_ff) : ERR_W'(error_ff);

      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET:    target_in = csr_wdata;
            CSR_P_GAIN:    p_gain_in = csr_wdata;
            CSR_D_GAIN:    d_gain_in = csr_wdata;
            CSR_SLEW:      slew_in   = csr_wdata[SLEW_W-1:0];
            CSR_HOLD:      hold_in   = csr_wdata;
            CSR_THRESHOLD: thr_in    = csr_wdata;
            default: begin
            end
         endcase
      end

      if (accept) begin
         error_in = ERR_W'(target_ff) - ERR_W'(req_position);
         now_in   = req_time_ms;
      end

      case (state_ff)
         ST_CHECK: begin
            neg_in = diff[DIFF_W-1];
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               deriv_in      = neg_ff ? -DER_W'(div_rsp.quotient)
                                      : DER_W'(div_rsp.quotient);
               last_time_in  = now_ff;
               last_error_in = error_ff;
            end
         end
         ST_MUL_D: begin
            pprod_in = product;
         end
         ST_SUM: begin
            // P term in Q.8 is moved to Q.16 before the D term is added.
            sum_in = {pprod_ff[SUM_W-9:0], 8'd0} + SUM_W'(product);
         end
         ST_SCALE: begin
            if (scaled > (SUM_W-16)'(32767)) begin
               cmd_in = 16'sh7FFF;
            end else if (scaled < -(SUM_W-16)'(32768)) begin
               cmd_in = -16'sh8000;
            end else begin
               cmd_in = scaled[POS_W-1:0];
            end
            pending_in = 1'b0;
         end
         ST_SLEW_DONE: begin
            if (!pending_ff) begin
               if (delta > limit) begin
                  drive_in = POS_W'(last_ext + limit);
               end else if (delta < -limit) begin
                  drive_in = POS_W'(last_ext - limit);
               end else begin
                  drive_in = cmd_ff;
               end
               settled_in    = ({1'b0, thr_ff} >= err_mag) && (deriv_ff == '0);
               last_drive_in = drive_in;
               pending_in    = 1'b1;
            end
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_drive_in   = drive_in;
               rsp_error_in   = error_ff;
               rsp_settled_in = settled_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         target_ff     <= '0;
         p_gain_ff     <= '0;
         d_gain_ff     <= '0;
         slew_ff       <= SLEW_RESET;
         hold_ff       <= HOLD_RESET;
         thr_ff        <= '0;
         last_time_ff  <= '0;
         last_error_ff <= '0;
         deriv_ff      <= '0;
         last_drive_ff <= '0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         target_ff     <= target_in;
         p_gain_ff     <= p_gain_in;
         d_gain_ff     <= d_gain_in;
         slew_ff       <= slew_in;
         hold_ff       <= hold_in;
         thr_ff        <= thr_in;
         last_time_ff  <= last_time_in;
         last_error_ff <= last_error_in;
         deriv_ff      <= deriv_in;
         last_drive_ff <= last_drive_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      error_ff       <= error_in;
      now_ff         <= now_in;
      neg_ff         <= neg_in;
      pprod_ff       <= pprod_in;
      sum_ff         <= sum_in;
      cmd_ff         <= cmd_in;
      drive_ff       <= drive_in;
      settled_ff     <= settled_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_error_ff   <= rsp_error_in;
      rsp_settled_ff <= rsp_settled_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_error_now = rsp_error_ff;
   assign rsp_settled   = rsp_settled_ff;

endmodule

`default_nettype wire

// ===== verif/tb_pd_controller_with_slew_limit.sv =====
`timescale 1ns / 1ps

module tb_pd_controller_with_slew_limit;
   import pdsl_pkg::*;

   // The watchdog counts cycles in which no beat moves on any port. The slowest
   // legal tick is a derivative refresh plus the longest send gap and receiver
   // stall, so this limit leaves a wide margin.
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_PHASES   = 10;
   localparam int TICKS_PER_PHASE = 53;

   // Indexes past the end of the register file. Writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [POS_W-1:0] drive;
      logic [ERR_W-1:0] error_now;
      logic             settled;
   } tick_result_type;

   // One row of the bring-up table: either a register write or a tick. Rows
   // with known set carry a result that is obvious by inspection.
   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
      logic [POS_W-1:0]      position;
      logic [TIME_W-1:0]     time_ms;
      logic                  known;
      tick_result_type       want;
   } bringup_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [POS_W-1:0] req_position;
   logic [TIME_W-1:0]       req_time_ms;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_drive;
   logic signed [ERR_W-1:0] rsp_error_now;
   logic                    rsp_settled;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // Our own copy of the register file and of the controller state.
   logic signed [POS_W-1:0] cfg_target;
   logic signed [POS_W-1:0] cfg_p_gain;
   logic signed [POS_W-1:0] cfg_d_gain;
   logic [SLEW_W-1:0]       cfg_slew;
   logic [HOLD_W-1:0]       cfg_hold;
   logic [THR_W-1:0]        cfg_threshold;
   logic [TIME_W-1:0]       held_since;   // timestamp of the last rate refresh
   longint                  held_error;   // error at the last rate refresh
   longint                  held_rate;    // error rate, Q.8 counts per ms
   longint                  prev_drive;

   bringup_row_type bringup_rows[$];
   tick_result_type drive_due[$];

   bit calm = 1'b0;   // when set, neither side inserts gaps
   int rsp_stall_left = 0;
   int quiet_cycles = 0;
   int ticks_sent = 0;
   int writes_done = 0;
   int results_checked = 0;
   int settled_seen = 0;
   int mismatches = 0;

   pd_controller_with_slew_limit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_position  (req_position),
      .req_time_ms   (req_time_ms),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .rsp_error_now (rsp_error_now),
      .rsp_settled   (rsp_settled),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_model();
      cfg_target    = '0;
      cfg_p_gain    = '0;
      cfg_d_gain    = '0;
      cfg_slew      = SLEW_RESET;
      cfg_hold      = HOLD_RESET;
      cfg_threshold = '0;
      held_since    = '0;
      held_error    = 0;
      held_rate     = 0;
      prev_drive    = 0;
   endfunction

   function automatic void apply_setting(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TARGET:    cfg_target    = data;
         CSR_P_GAIN:    cfg_p_gain    = data;
         CSR_D_GAIN:    cfg_d_gain    = data;
         CSR_SLEW:      cfg_slew      = data[SLEW_W-1:0];
         CSR_HOLD:      cfg_hold      = data;
         CSR_THRESHOLD: cfg_threshold = data;
         default:       ;
      endcase
   endfunction

   // Works out the beat that one tick must produce and advances the state.
   function automatic tick_result_type compute_drive(input logic signed [POS_W-1:0] pos,
                                                     input logic [TIME_W-1:0] stamp);
      tick_result_type   r;
      logic [TIME_W-1:0] dt;
      longint            err;
      longint            span;
      longint            cmd;
      longint            slew;
      longint            mag;
      longint            thr;
      err = longint'(cfg_target) - longint'(pos);
      dt  = stamp - held_since;
      // The interval compare is unsigned, so a clock that steps back refreshes.
      if (err != held_error || dt > cfg_hold) begin
         span = dt;
         if (dt == '0) begin
            span = 1;
         end
         held_rate  = ((err - held_error) * 256) / span;
         held_since = stamp;
         held_error = err;
      end
      cmd = (longint'(cfg_p_gain) * err * 256 + longint'(cfg_d_gain) * held_rate) / 65536;
      if (cmd > 32767) begin
         cmd = 32767;
      end else if (cmd < -32768) begin
         cmd = -32768;
      end
      slew = cfg_slew;
      if (cmd - prev_drive > slew) begin
         cmd = prev_drive + slew;
      end else if (cmd - prev_drive < -slew) begin
         cmd = prev_drive - slew;
      end
      prev_drive = cmd;
      mag = (err < 0) ? -err : err;
      thr = cfg_threshold;
      r.drive     = cmd[POS_W-1:0];
      r.error_now = err[ERR_W-1:0];
      r.settled   = (mag <= thr) && (held_rate == 0);
      return r;
   endfunction

   function automatic int pick_wait();
      return calm ? 0 : int'($urandom_range(0, 5));
   endfunction

   // Register values: extremes about forty percent of the time, otherwise values
   // that keep the loop out of saturation often enough to be interesting.
   function automatic logic [CSR_DATA_W-1:0] pick_setting(input logic [CSR_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 16'h0000;
         1: v = 16'h7FFF;
         2: v = 16'h8000;
         3: v = 16'hFFFF;
         default: begin
            case (idx) inside
               CSR_P_GAIN, CSR_D_GAIN: v = CSR_DATA_W'($urandom_range(0, 2047)) - 16'd1024;
               CSR_SLEW:               v = CSR_DATA_W'($urandom_range(0, 3000));
               CSR_HOLD:               v = CSR_DATA_W'($urandom_range(0, 300));
               CSR_THRESHOLD:          v = CSR_DATA_W'($urandom_range(0, 40));
               default:                v = CSR_DATA_W'($urandom);
            endcase
         end
      endcase
      return v;
   endfunction

   // Positions: repeats (unchanged error), small offsets around the setpoint so
   // the settled flag can rise, rail values, and fully random samples.
   function automatic logic signed [POS_W-1:0] pick_position(input logic signed [POS_W-1:0] prev);
      logic signed [POS_W-1:0] v;
      longint                  near;
      v = POS_W'($urandom);
      case ($urandom_range(0, 9)) inside
         0, 1, 2: v = prev;
         3, 4, 5: begin
            near = longint'(cfg_target) + longint'($urandom_range(0, 16)) - 8;
            if (near > 32767) begin
               near = 32767;
            end else if (near < -32768) begin
               near = -32768;
            end
            v = near[POS_W-1:0];
         end
         6:       v = 16'h8000;
         7:       v = 16'h7FFF;
         default: ;
      endcase
      return v;
   endfunction

   // Timestamps mostly move forward by about the hold time, with repeats,
   // backward steps, jumps and runs across the 32 bit wrap mixed in.
   function automatic logic [TIME_W-1:0] pick_time(input logic [TIME_W-1:0] prev);
      case ($urandom_range(0, 11))
         0:       return prev;
         1:       return prev - $urandom_range(1, 5000);
         2:       return $urandom;
         3:       return 32'hFFFF_FFFF - $urandom_range(0, 20);
         default: return prev + $urandom_range(1, int'(cfg_hold) + 20);
      endcase
   endfunction

   function automatic void row_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      bringup_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.csr_idx  = idx;
      row.csr_data = data;
      bringup_rows.push_back(row);
   endfunction

   function automatic void row_tick(input logic [POS_W-1:0] pos, input logic [TIME_W-1:0] stamp,
                                    input logic known, input logic [POS_W-1:0] drv,
                                    input logic [ERR_W-1:0] err, input logic stl);
      bringup_row_type row;
      row                = '0;
      row.position       = pos;
      row.time_ms        = stamp;
      row.known          = known;
      row.want.drive     = drv;
      row.want.error_now = err;
      row.want.settled   = stl;
      bringup_rows.push_back(row);
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is
   // taken. Valid stays up across back-to-back ticks with no gap.
   task automatic send_tick(input logic [POS_W-1:0] pos, input logic [TIME_W-1:0] stamp,
                            input logic known, input tick_result_type want);
      tick_result_type r;
      int              gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      req_time_ms  <= stamp;
      do @(posedge clock); while (!req_ready);
      r = compute_drive(pos, stamp);
      drive_due.push_back(known ? want : r);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (drive_due.size() != 0) @(negedge clock);
   endtask

   // Every tick yields exactly one beat, so an empty queue means the block is idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_setting(idx, data);
      writes_done++;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver: ready drops for a freshly drawn number of cycles after each beat.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every result beat is matched against the oldest outstanding prediction.
   always @(posedge clock) begin : rsp_check
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_due.size() == 0) begin
            $error("result beat arrived with no tick outstanding");
            mismatches++;
         end else begin
            want = drive_due.pop_front();
            if (rsp_drive !== want.drive) begin
               $error("drive: expected %0d, got %0d", $signed(want.drive), rsp_drive);
               mismatches++;
            end
            if (rsp_error_now !== want.error_now) begin
               $error("error_now: expected %0d, got %0d", $signed(want.error_now),
                      rsp_error_now);
               mismatches++;
            end
            if (rsp_settled !== want.settled) begin
               $error("settled: expected %0d, got %0d", want.settled, rsp_settled);
               mismatches++;
            end
            results_checked++;
            if (want.settled) begin
               settled_seen++;
            end
         end
         rsp_stall_left = pick_wait();
      end
   end

   // Watchdog: a run that stops moving beats for too long is a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic signed [POS_W-1:0] pos;
      logic [TIME_W-1:0]       now_ms;
      int                      phase;
      int                      n;
      int                      k;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_position = '0;
      req_time_ms  = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      clear_model();

      // Bring-up table. Straight out of reset the error is zero, the gains are
      // zero and the flag is settled.
      row_tick(16'sd0, 32'd0, 1'b1, 16'sd0, 17'sd0, 1'b1);
      // Largest negative position at the same timestamp: a zero interval, which
      // must divide as one.
      row_tick(16'h8000, 32'd0, 1'b1, 16'sd0, 17'sd32768, 1'b0);
      // Same error inside the hold time keeps the rate; past it the rate is
      // refreshed to zero.
      row_tick(16'h8000, 32'd50, 1'b0, '0, '0, 1'b0);
      row_tick(16'h8000, 32'd200, 1'b0, '0, '0, 1'b0);
      // The timestamp steps backwards, which reads as a very long interval.
      row_tick(16'h8000, 32'd150, 1'b0, '0, '0, 1'b0);
      row_tick(16'h7FFF, 32'd160, 1'b0, '0, '0, 1'b0);
      // Full scale error with full gain pins the command at the rail; the
      // default slew limit then walks the drive one full step at a time.
      row_write(CSR_TARGET, 16'h7FFF);
      row_write(CSR_P_GAIN, 16'h7FFF);
      row_tick(16'h8000, 32'd300, 1'b1, 16'sd32767, 17'sd65535, 1'b0);
      row_write(CSR_TARGET, 16'h8000);
      row_tick(16'h7FFF, 32'd310, 1'b1, 16'sd0, -17'sd65535, 1'b0);
      row_tick(16'h7FFF, 32'd320, 1'b1, -16'sd32767, -17'sd65535, 1'b0);
      row_tick(16'h7FFF, 32'd330, 1'b1, 16'h8000, -17'sd65535, 1'b0);
      // A slew limit of zero freezes the drive. Bit 15 of the write is dropped.
      row_write(CSR_SLEW, 16'h8000);
      row_write(CSR_TARGET, 16'h0000);
      row_tick(16'sd0, 32'd340, 1'b1, 16'h8000, 17'sd0, 1'b0);
      // Opposite gain extremes, no hold time and the widest settle window.
      row_write(CSR_SLEW, 16'hFFFF);
      row_write(CSR_P_GAIN, 16'h8000);
      row_write(CSR_D_GAIN, 16'h7FFF);
      row_write(CSR_HOLD, 16'h0000);
      row_write(CSR_THRESHOLD, 16'hFFFF);
      row_tick(16'sd1000, 32'd340, 1'b0, '0, '0, 1'b0);
      row_tick(16'sd1000, 32'd341, 1'b0, '0, '0, 1'b0);
      row_tick(-16'sd1, 32'd341, 1'b0, '0, '0, 1'b0);
      // Unity proportional gain, the longest hold time and a narrow window.
      row_write(CSR_P_GAIN, 16'h0100);
      row_write(CSR_D_GAIN, 16'h8000);
      row_write(CSR_HOLD, 16'hFFFF);
      row_write(CSR_THRESHOLD, 16'd5);
      row_tick(16'sd3, 32'd400, 1'b0, '0, '0, 1'b0);
      row_tick(-16'sd4, 32'd500, 1'b0, '0, '0, 1'b0);
      row_tick(-16'sd4, 32'd600, 1'b0, '0, '0, 1'b0);
      row_tick(-16'sd4, 32'd70000, 1'b0, '0, '0, 1'b0);
      // Writes to indexes past the register file must change nothing.
      row_write(CSR_SPARE_LO, 16'hFFFF);
      row_write(CSR_SPARE_HI, 16'h8000);
      row_tick(16'sd12345, 32'd70001, 1'b0, '0, '0, 1'b0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (bringup_rows[i]) begin
         if (bringup_rows[i].is_write) begin
            write_register(bringup_rows[i].csr_idx, bringup_rows[i].csr_data);
         end else begin
            send_tick(bringup_rows[i].position, bringup_rows[i].time_ms,
                      bringup_rows[i].known, bringup_rows[i].want);
         end
      end

      // Random phases. Each one rewrites a random subset of the registers
      // (all of them in the first phase) and then runs a stream of ticks.
      // Every third phase runs with no gaps on either side.
      pos    = 16'sd12345;
      now_ms = 32'd70001;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         calm = (phase % 3 == 2);
         for (k = int'(CSR_TARGET); k <= int'(CSR_THRESHOLD); k++) begin
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
               write_register(CSR_IDX_W'(k), pick_setting(CSR_IDX_W'(k)));
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            write_register(CSR_SPARE_HI, CSR_DATA_W'($urandom));
         end
         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            pos    = pick_position(pos);
            now_ms = pick_time(now_ms);
            send_tick(pos, now_ms, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d ticks and %0d register writes across %0d random phases",
               ticks_sent, writes_done, RANDOM_PHASES);
      $display("checked %0d result beats, %0d of them with the settled flag up",
               results_checked, settled_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pdsl_pkg.sv
hw/rtl/pdsl_divider.sv
hw/rtl/pdsl_mul.sv
hw/rtl/pd_controller_with_slew_limit.sv
verif/tb_pd_controller_with_slew_limit.sv
